// ----- hdl/trs_pkg.sv -----
package trs_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ANG_FRAC = 24;
	localparam int CORDIC_STEPS = 20;
	localparam int ITER_PER_STAGE = 4;
	localparam int CORDIC_STAGES = CORDIC_STEPS / ITER_PER_STAGE;
	// s1..s4 reduce the angle, then CORDIC, then five stages that scale, multiply and saturate
	localparam int PIPE_DEPTH = 9 + CORDIC_STAGES;

	localparam longint GAIN_Q30 = 64'sd652032874;
	localparam longint M360 = 64'sd360 <<< FRAC_BITS;
	localparam longint QUARTER = 64'sd90 <<< FRAC_BITS;
	localparam longint OFFSET = M360 * (((64'sd1 <<< 31) + M360 - 1) / M360);
	localparam int RED_STEPS = $clog2((64'sd1 <<< 32) / M360 + 2);
	localparam int RED_HALF = RED_STEPS / 2;

	localparam int RW = 34;
	localparam int XW = 34;
	localparam int ZW = 33;
	localparam int SC_W = FRAC_BITS + 2;
	localparam int ROT_W = FRAC_BITS + 3;
	localparam int PW = ROT_W + 32;

	localparam logic [1:0] ROW_LAST = 2'd3;

	typedef logic signed [31:0] q_t;
	typedef logic signed [SC_W-1:0] sc_t;
	typedef logic signed [ROT_W-1:0] rot_t;
	typedef logic signed [XW-1:0] xy_t;
	typedef logic signed [ZW-1:0] z_t;

	// atan(2^-i) in degrees, Q24
	function automatic z_t atan_q24(input int i);
		z_t r;
		case (i)
			0: r = 33'sd754974720;
			1: r = 33'sd445687602;
			2: r = 33'sd235489088;
			3: r = 33'sd119537938;
			4: r = 33'sd60000934;
			5: r = 33'sd30029717;
			6: r = 33'sd15018523;
			7: r = 33'sd7509720;
			8: r = 33'sd3754917;
			9: r = 33'sd1877466;
			10: r = 33'sd938734;
			11: r = 33'sd469367;
			12: r = 33'sd234683;
			13: r = 33'sd117342;
			14: r = 33'sd58671;
			15: r = 33'sd29335;
			16: r = 33'sd14668;
			17: r = 33'sd7334;
			18: r = 33'sd3667;
			19: r = 33'sd1833;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- hdl/trs_transform_matrix_builder_core.sv -----
// Path: row 0 of a matrix appears after its input beat passes the 14 pipeline stages
// and the row buffer; rows 1..3 follow one per cycle while m_tready is high.
// Flow: the row buffer emits a matrix as four rows over four output beats and loads
// the next only as its last row goes; the pipeline takes a beat per cycle unless stalled.
// Reset: arst_n clears all valid bits and the row buffer's valid and row index at once; no clearing pass.
module trs_transform_matrix_builder_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// scale_x, scale_y, scale_z, angle_x_deg, angle_y_deg, angle_z_deg,
	// shift_x, shift_y, shift_z (32 bits each, lowest first)
	input  logic [287:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// col_0, col_1, col_2, col_3 (32 bits each, lowest first)
	output logic [127:0] m_tdata,
	// row_index
	output logic [1:0]   m_tuser,
	output logic         m_tlast
);

	localparam int D = trs_pkg::PIPE_DEPTH;
	localparam int NC = trs_pkg::CORDIC_STAGES;

	logic en;
	logic ser_take;
	logic vld_s [1:D];

	trs_pkg::q_t scale_s [1:D][3];
	trs_pkg::q_t shift_s [1:D][3];

	logic [trs_pkg::RW-1:0] red_s1 [3];
	logic [trs_pkg::RW-1:0] red_s2 [3];
	logic [trs_pkg::RW-1:0] red_s3 [3];

	// index 0 is s4, index c+1 is stage 5+c
	trs_pkg::xy_t cx_s [0:NC][3];
	trs_pkg::xy_t cy_s [0:NC][3];
	trs_pkg::z_t  cz_s [0:NC][3];
	logic [1:0]   quad_s [0:NC][3];

	trs_pkg::sc_t sin_s10 [3];
	trs_pkg::sc_t cos_s10 [3];

	trs_pkg::sc_t sysx_s11, cysx_s11, cycz_s11, cysz_s11, sycx_s11, cxsz_s11;
	trs_pkg::sc_t cxcz_s11, sysz_s11, sycz_s11, cycx_s11, nsx_s11, sz_s11, cz_s11;

	trs_pkg::rot_t rot_s12 [3][3];
	logic signed [trs_pkg::PW-1:0] prod_s13 [3][3];
	trs_pkg::q_t mat_s14 [3][3];

	trs_pkg::q_t mat_q [3][3];
	trs_pkg::q_t shf_q [3];
	logic [1:0]  row_q;
	logic        out_vld_q;

	function automatic logic [trs_pkg::RW-1:0] mod_part(input logic [trs_pkg::RW-1:0] v,
			input int hi, input int lo);
		logic [trs_pkg::RW-1:0] t;
		t = v;
		for (int k = hi; k >= lo; k--) begin
			if (t >= trs_pkg::RW'(trs_pkg::M360 <<< k))
				t = t - trs_pkg::RW'(trs_pkg::M360 <<< k);
		end
		return t;
	endfunction

	function automatic trs_pkg::sc_t fm(input trs_pkg::sc_t a, input trs_pkg::sc_t b);
		logic signed [2*trs_pkg::SC_W-1:0] p;
		p = a * b;
		p = p + ((2*trs_pkg::SC_W)'(1) << (trs_pkg::FRAC_BITS - 1));
		p = p >>> trs_pkg::FRAC_BITS;
		return p[trs_pkg::SC_W-1:0];
	endfunction

	function automatic trs_pkg::sc_t to_qf(input trs_pkg::xy_t x);
		trs_pkg::xy_t t;
		trs_pkg::xy_t one;
		one = trs_pkg::XW'(1) <<< trs_pkg::FRAC_BITS;
		t = x + (trs_pkg::XW'(1) <<< (29 - trs_pkg::FRAC_BITS));
		t = t >>> (30 - trs_pkg::FRAC_BITS);
		if (t > one)
			t = one;
		if (t < -one)
			t = -one;
		return t[trs_pkg::SC_W-1:0];
	endfunction

	assign ser_take = !out_vld_q || (m_tready && row_q == trs_pkg::ROW_LAST);
	assign en = !vld_s[D] || ser_take;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= D; k++)
				vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= s_tvalid;
			for (int k = 2; k <= D; k++)
				vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				scale_s[1][j] <= s_tdata[32*j +: 32];
				shift_s[1][j] <= s_tdata[32*(6+j) +: 32];
			end
			for (int k = 2; k <= D; k++) begin
				scale_s[k] <= scale_s[k-1];
				shift_s[k] <= shift_s[k-1];
			end
		end
	end

	// angle reduction and quadrant fold
	always_ff @(posedge clk) begin
		logic [trs_pkg::RW-1:0] rem;
		logic [1:0] q;
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				red_s1[a] <= trs_pkg::RW'($signed(s_tdata[32*(3+a) +: 32]))
					+ trs_pkg::RW'(trs_pkg::OFFSET);
				red_s2[a] <= mod_part(red_s1[a], trs_pkg::RED_STEPS - 1, trs_pkg::RED_HALF);
				red_s3[a] <= mod_part(red_s2[a], trs_pkg::RED_HALF - 1, 0);
				rem = red_s3[a];
				q = 2'd0;
				if (rem >= trs_pkg::RW'(2 * trs_pkg::QUARTER)) begin
					rem = rem - trs_pkg::RW'(2 * trs_pkg::QUARTER);
					q[1] = 1'b1;
				end
				if (rem >= trs_pkg::RW'(trs_pkg::QUARTER)) begin
					rem = rem - trs_pkg::RW'(trs_pkg::QUARTER);
					q[0] = 1'b1;
				end
				quad_s[0][a] <= q;
				cz_s[0][a] <= trs_pkg::ZW'(rem) <<< (trs_pkg::ANG_FRAC - trs_pkg::FRAC_BITS);
				cx_s[0][a] <= trs_pkg::XW'(trs_pkg::GAIN_Q30);
				cy_s[0][a] <= '0;
			end
		end
	end

	// CORDIC, several rotations per stage
	always_ff @(posedge clk) begin
		trs_pkg::xy_t x, y, dx, dy;
		trs_pkg::z_t z;
		if (en) begin
			for (int c = 0; c < NC; c++) begin
				for (int a = 0; a < 3; a++) begin
					x = cx_s[c][a];
					y = cy_s[c][a];
					z = cz_s[c][a];
					for (int j = 0; j < trs_pkg::ITER_PER_STAGE; j++) begin
						dx = y >>> (c * trs_pkg::ITER_PER_STAGE + j);
						dy = x >>> (c * trs_pkg::ITER_PER_STAGE + j);
						if (z >= 0) begin
							x = x - dx;
							y = y + dy;
							z = z - trs_pkg::atan_q24(c * trs_pkg::ITER_PER_STAGE + j);
						end else begin
							x = x + dx;
							y = y - dy;
							z = z + trs_pkg::atan_q24(c * trs_pkg::ITER_PER_STAGE + j);
						end
					end
					cx_s[c+1][a] <= x;
					cy_s[c+1][a] <= y;
					cz_s[c+1][a] <= z;
					quad_s[c+1][a] <= quad_s[c][a];
				end
			end
		end
	end

	// scale to Q(FRAC_BITS) and unfold the quadrant
	always_ff @(posedge clk) begin
		trs_pkg::sc_t cv, sv;
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				cv = to_qf(cx_s[NC][a]);
				sv = to_qf(cy_s[NC][a]);
				case (quad_s[NC][a])
					2'd0: begin
						cos_s10[a] <= cv;
						sin_s10[a] <= sv;
					end
					2'd1: begin
						cos_s10[a] <= -sv;
						sin_s10[a] <= cv;
					end
					2'd2: begin
						cos_s10[a] <= -cv;
						sin_s10[a] <= -sv;
					end
					default: begin
						cos_s10[a] <= sv;
						sin_s10[a] <= -cv;
					end
				endcase
			end
		end
	end

	// rotation Ry*Rx*Rz, then scale each column and saturate
	always_ff @(posedge clk) begin
		logic signed [trs_pkg::PW-1:0] t;
		if (en) begin
			sysx_s11 <= fm(sin_s10[1], sin_s10[0]);
			cysx_s11 <= fm(cos_s10[1], sin_s10[0]);
			cycz_s11 <= fm(cos_s10[1], cos_s10[2]);
			cysz_s11 <= fm(cos_s10[1], sin_s10[2]);
			sycx_s11 <= fm(sin_s10[1], cos_s10[0]);
			cxsz_s11 <= fm(cos_s10[0], sin_s10[2]);
			cxcz_s11 <= fm(cos_s10[0], cos_s10[2]);
			sysz_s11 <= fm(sin_s10[1], sin_s10[2]);
			sycz_s11 <= fm(sin_s10[1], cos_s10[2]);
			cycx_s11 <= fm(cos_s10[1], cos_s10[0]);
			nsx_s11 <= -sin_s10[0];
			sz_s11 <= sin_s10[2];
			cz_s11 <= cos_s10[2];

			rot_s12[0][0] <= trs_pkg::ROT_W'(cycz_s11) + trs_pkg::ROT_W'(fm(sysx_s11, sz_s11));
			rot_s12[0][1] <= trs_pkg::ROT_W'(fm(sysx_s11, cz_s11)) - trs_pkg::ROT_W'(cysz_s11);
			rot_s12[0][2] <= trs_pkg::ROT_W'(sycx_s11);
			rot_s12[1][0] <= trs_pkg::ROT_W'(cxsz_s11);
			rot_s12[1][1] <= trs_pkg::ROT_W'(cxcz_s11);
			rot_s12[1][2] <= trs_pkg::ROT_W'(nsx_s11);
			rot_s12[2][0] <= trs_pkg::ROT_W'(fm(cysx_s11, sz_s11)) - trs_pkg::ROT_W'(sycz_s11);
			rot_s12[2][1] <= trs_pkg::ROT_W'(sysz_s11) + trs_pkg::ROT_W'(fm(cysx_s11, cz_s11));
			rot_s12[2][2] <= trs_pkg::ROT_W'(cycx_s11);

			for (int r = 0; r < 3; r++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s13[r][j] <= rot_s12[r][j] * scale_s[12][j];
					t = prod_s13[r][j] + (trs_pkg::PW'(1) <<< (trs_pkg::FRAC_BITS - 1));
					t = t >>> trs_pkg::FRAC_BITS;
					if (t > trs_pkg::PW'(64'sd2147483647))
						mat_s14[r][j] <= 32'sh7fffffff;
					else if (t < -(trs_pkg::PW'(64'sd2147483648)))
						mat_s14[r][j] <= 32'sh80000000;
					else
						mat_s14[r][j] <= t[31:0];
				end
			end
		end
	end

	// row buffer: hold one matrix, emit a row per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			row_q <= '0;
		end else if (vld_s[D] && ser_take) begin
			out_vld_q <= 1'b1;
			row_q <= '0;
		end else if (out_vld_q && m_tready) begin
			if (row_q == trs_pkg::ROW_LAST)
				out_vld_q <= 1'b0;
			else
				row_q <= row_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s[D] && ser_take) begin
			mat_q <= mat_s14;
			shf_q <= shift_s[D];
		end
	end

	always_comb begin
		if (row_q == trs_pkg::ROW_LAST) begin
			m_tdata = {32'(64'sd1 <<< trs_pkg::FRAC_BITS), 96'd0};
		end else begin
			m_tdata = {shf_q[row_q], mat_q[row_q][2], mat_q[row_q][1], mat_q[row_q][0]};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser = row_q;
	assign m_tlast = (row_q == trs_pkg::ROW_LAST);

`ifndef SYNTH
	a_row_advance: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && m_tready && row_q != trs_pkg::ROW_LAST
		|=> out_vld_q && row_q == $past(row_q) + 2'd1)
		else $error("row did not advance after a taken beat");

	a_hold_tail: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[D] && !ser_take |=> vld_s[D] && $stable(mat_s14[0][0]))
		else $error("pipeline tail lost an item while stalled");

	a_bottom_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[95:0] == 96'd0
		&& m_tdata[127:96] == 32'(64'sd1 <<< trs_pkg::FRAC_BITS))
		else $error("bottom row is not 0,0,0,1");

	a_no_load_midframe: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && row_q != trs_pkg::ROW_LAST |-> !ser_take)
		else $error("row buffer reloaded before last row");
`endif

endmodule

// ----- tb/sv/trs_transform_matrix_builder_core_tb.sv -----
module trs_transform_matrix_builder_core_tb;

	localparam int N_RANDOM = 360;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [1:0]  row;
		logic [31:0] c0;
		logic [31:0] c1;
		logic [31:0] c2;
		logic [31:0] c3;
		logic        last;
	} row_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [287:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;

	logic [287:0] pending_beats[$];
	row_t         expected_rows[$];
	int           errors = 0;
	int           cycles = 0;
	int           send_wait = 0;
	int           recv_wait = 0;
	bit           stimulus_done = 0;

	trs_transform_matrix_builder_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic longint shr_floor(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint qmul(longint a, longint b);
		return shr_floor(a * b + (64'sd1 <<< (trs_pkg::FRAC_BITS - 1)), trs_pkg::FRAC_BITS);
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint q30_to_frac(longint v);
		longint one;
		longint r;
		one = 64'sd1 <<< trs_pkg::FRAC_BITS;
		r = shr_floor(v + (64'sd1 <<< (29 - trs_pkg::FRAC_BITS)), 30 - trs_pkg::FRAC_BITS);
		if (r > one)
			r = one;
		if (r < -one)
			r = -one;
		return r;
	endfunction

	task automatic sine_cosine(input longint angle, output longint s, output longint c);
		longint m;
		longint r;
		longint quarter;
		longint x;
		longint y;
		longint z;
		longint q;
		longint dx;
		longint dy;
		longint cv;
		longint sv;
		m = 64'sd360 <<< trs_pkg::FRAC_BITS;
		quarter = 64'sd90 <<< trs_pkg::ANG_FRAC;
		r = angle % m;
		if (r < 0)
			r += m;
		r = r * (64'sd1 <<< (trs_pkg::ANG_FRAC - trs_pkg::FRAC_BITS));
		q = r / quarter;
		z = r - q * quarter;
		x = trs_pkg::GAIN_Q30;
		y = 0;
		for (int i = 0; i < trs_pkg::CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(trs_pkg::atan_q24(i));
			end else begin
				x += dx; y -= dy; z += longint'(trs_pkg::atan_q24(i));
			end
		end
		cv = q30_to_frac(x);
		sv = q30_to_frac(y);
		case (q & 3)
			0: begin c = cv; s = sv; end
			1: begin c = -sv; s = cv; end
			2: begin c = -cv; s = -sv; end
			default: begin c = sv; s = -cv; end
		endcase
	endtask

	// Build the four rows of T * Ry * Rx * Rz * S for one beat.
	task automatic predict_matrix(input logic [287:0] d);
		longint fld[9];
		longint rot[3][3];
		longint sx, cx, sy, cy, sz, cz, sysx, cysx;
		longint v[3];
		row_t   rw;
		for (int k = 0; k < 9; k++)
			fld[k] = longint'($signed(d[32*k +: 32]));
		sine_cosine(fld[3], sx, cx);
		sine_cosine(fld[4], sy, cy);
		sine_cosine(fld[5], sz, cz);
		sysx = qmul(sy, sx);
		cysx = qmul(cy, sx);
		rot[0][0] = qmul(cy, cz) + qmul(sysx, sz);
		rot[0][1] = qmul(sysx, cz) - qmul(cy, sz);
		rot[0][2] = qmul(sy, cx);
		rot[1][0] = qmul(cx, sz);
		rot[1][1] = qmul(cx, cz);
		rot[1][2] = -sx;
		rot[2][0] = qmul(cysx, sz) - qmul(sy, cz);
		rot[2][1] = qmul(sy, sz) + qmul(cysx, cz);
		rot[2][2] = qmul(cy, cx);
		for (int r = 0; r < 4; r++) begin
			for (int j = 0; j < 3; j++)
				v[j] = (r < 3) ? clamp32(qmul(rot[r][j], fld[j])) : 0;
			rw.row = r[1:0];
			rw.c0 = v[0][31:0];
			rw.c1 = v[1][31:0];
			rw.c2 = v[2][31:0];
			rw.c3 = (r < 3) ? fld[6 + r][31:0] : 32'(64'sd1 <<< trs_pkg::FRAC_BITS);
			rw.last = (r == 3);
			expected_rows.push_back(rw);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		errors++;
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0001_0000 * $urandom_range(0, 8) - 32'h0004_0000;
			default: return $urandom();
		endcase
	endfunction

	// Mostly modest scales and angles; the rest spans the whole range.
	function automatic logic [287:0] random_beat();
		logic [287:0] d;
		for (int k = 0; k < 9; k++) begin
			if ($urandom_range(0, 3) == 0)
				d[32*k +: 32] = pick_value();
			else if (k < 3)
				d[32*k +: 32] = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
			else if (k < 6)
				d[32*k +: 32] = $urandom_range(0, 32'h02d0_0000) - 32'h0168_0000;
			else
				d[32*k +: 32] = $urandom();
		end
		return d;
	endfunction

	initial begin
		logic [287:0] d;
		int angles[8];
		angles = '{0, 90, 180, 270, 360, -90, 45, 720};
		arst_n = 1'b0;
		// identity-ish scale with quadrant and wrap angles on each axis
		for (int a = 0; a < 8; a++) begin
			d = '0;
			for (int k = 0; k < 3; k++)
				d[32*k +: 32] = 32'h0001_0000;
			d[32*(3 + a % 3) +: 32] = angles[a] * 32'h0001_0000;
			d[32*6 +: 32] = a;
			pending_beats.push_back(d);
		end
		pending_beats.push_back({9{32'h8000_0000}});
		pending_beats.push_back({9{32'h7fff_ffff}});
		pending_beats.push_back('0);
		pending_beats.push_back({9{32'hffff_ffff}});
		pending_beats.push_back({{3{32'h8000_0000}}, 32'h002d_0000, 32'h002d_0000,
			32'h002d_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
		pending_beats.push_back({{3{32'h1234_5678}}, 32'hfe98_0000, 32'h0168_0000,
			32'h7fff_0000, {3{32'h8000_0000}}});
		for (int n = 0; n < N_RANDOM; n++)
			pending_beats.push_back(random_beat());
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk or negedge arst_n) begin
		int gap;
		gap = $urandom_range(0, 6);
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			send_wait <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_matrix(s_tdata);
				void'(pending_beats.pop_front());
			end
			if (s_tvalid && !s_tready) begin
				// hold the beat
			end else if (send_wait > 0) begin
				s_tvalid <= 1'b0;
				send_wait <= send_wait - 1;
			end else if (s_tvalid && s_tready && gap > 0) begin
				s_tvalid <= 1'b0;
				send_wait <= gap - 1;
			end else if (pending_beats.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= pending_beats[0];
			end else begin
				s_tvalid <= 1'b0;
				stimulus_done <= 1'b1;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		int gap;
		gap = $urandom_range(0, 6);
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_wait <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_rows.size() == 0) begin
					report_mismatch("unexpected row", {30'b0, m_tuser}, '0);
				end else begin
					row_t w;
					w = expected_rows.pop_front();
					if (m_tuser !== w.row)
						report_mismatch("row_index", {30'b0, m_tuser}, {30'b0, w.row});
					if (m_tdata[31:0] !== w.c0)
						report_mismatch("col_0", m_tdata[31:0], w.c0);
					if (m_tdata[63:32] !== w.c1)
						report_mismatch("col_1", m_tdata[63:32], w.c1);
					if (m_tdata[95:64] !== w.c2)
						report_mismatch("col_2", m_tdata[95:64], w.c2);
					if (m_tdata[127:96] !== w.c3)
						report_mismatch("col_3", m_tdata[127:96], w.c3);
					if (m_tlast !== w.last)
						report_mismatch("last_row", {31'b0, m_tlast}, {31'b0, w.last});
				end
			end
			if (recv_wait > 0) begin
				m_tready <= (recv_wait == 1);
				recv_wait <= recv_wait - 1;
			end else if (m_tvalid && m_tready && gap > 0) begin
				m_tready <= 1'b0;
				recv_wait <= gap;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		wait (arst_n);
		while (!(stimulus_done && expected_rows.size() == 0) && cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			repeat (40) @(posedge clk);
			if (errors == 0)
				$display("TEST PASSED");
			else
				$display("TEST FAILED");
			$finish;
		end
	end

endmodule
